// File: rtl/gna_pkg.sv
// ----------------------------------------------------------------------------
// gna_pkg
// Shared types and constants of the normalized aggregation block.
// ----------------------------------------------------------------------------
`default_nettype none

package gna_pkg;

	localparam int MAX_DIM     = 64;
	localparam int IDX_BITS    = 6;
	localparam int VALUE_BITS  = 32;
	localparam int DEGREE_BITS = 16;
	localparam int ACC_BITS    = 48;
	localparam int PROD_BITS   = 2 * DEGREE_BITS;
	localparam int VLEN_BITS   = 7;
	localparam int ADDR_BITS   = 3;

	localparam logic [VLEN_BITS-1:0] VLEN_RESET = 7'd64;

	localparam logic CMD_BIAS = 1'b0;
	localparam logic CMD_MSG  = 1'b1;

	localparam logic REG_VLEN = 1'b0;
	localparam logic REG_RELU = 1'b1;

	typedef struct packed {
		logic                          command;
		logic [IDX_BITS-1:0]           element_index;
		logic signed [VALUE_BITS-1:0]  value;
		logic [DEGREE_BITS-1:0]        node_degree;
		logic [DEGREE_BITS-1:0]        neighbor_degree;
		logic                          first_neighbor;
		logic                          last_neighbor;
	} msg_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]           out_index;
		logic signed [VALUE_BITS-1:0]  result_value;
		logic                          last_element;
		logic                          saturated;
	} res_t;

	typedef struct packed {
		logic                  start;
		logic [PROD_BITS-1:0]  p;
	} rsq_req_t;

	typedef struct packed {
		logic         done;
		logic [31:0]  s;
	} rsq_rsp_t;

	typedef enum logic [1:0] {
		RSQ_IDLE,
		RSQ_DIV,
		RSQ_SQRT,
		RSQ_DONE
	} rsq_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_BIAS,
		ST_SCALE,
		ST_MUL,
		ST_ACC,
		ST_FIN
	} gna_state_t;

endpackage

`default_nettype wire

// File: rtl/gna_rsqrt.sv
// ----------------------------------------------------------------------------
// gna_rsqrt
// Q1.31 reciprocal square root: floor(sqrt(floor(2^62 / p))), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gna_rsqrt
	import gna_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rsq_req_t req,
	output rsq_rsp_t      rsp
);

	rsq_state_t state_q, state_d;
	logic [5:0]            cnt_q;
	logic [PROD_BITS-1:0]  p_q;
	logic [PROD_BITS-1:0]  rem_q;
	logic [61:0]           quo_q;
	logic [63:0]           t_q, res_q, bit_q;

	logic [PROD_BITS:0]    rem_sh;
	logic                  ge;
	logic [PROD_BITS:0]    rem_sub;
	logic [63:0]           sum;
	logic                  take;

	assign rem_sh  = {rem_q, (cnt_q == 6'd0)};
	assign ge      = rem_sh >= {1'b0, p_q};
	assign rem_sub = rem_sh - {1'b0, p_q};
	assign sum     = res_q + bit_q;
	assign take    = t_q >= sum;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RSQ_IDLE: if (req.start) state_d = RSQ_DIV;
			RSQ_DIV:  if (cnt_q == 6'd62) state_d = RSQ_SQRT;
			RSQ_SQRT: if (cnt_q == 6'd31) state_d = RSQ_DONE;
			RSQ_DONE: state_d = RSQ_IDLE;
			default:  state_d = RSQ_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == RSQ_DONE);
		rsp.s    = res_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RSQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else                    cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			RSQ_IDLE: begin
				p_q   <= req.p;
				rem_q <= '0;
			end
			RSQ_DIV: begin
				rem_q <= ge ? rem_sub[PROD_BITS-1:0] : rem_sh[PROD_BITS-1:0];
				quo_q <= {quo_q[60:0], ge};
				if (cnt_q == 6'd62) begin
					t_q   <= {1'b0, quo_q, ge};
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			RSQ_SQRT: begin
				if (take) begin
					t_q   <= t_q - sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			RSQ_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/gcn_normalized_aggregate.sv
// ----------------------------------------------------------------------------
// gcn_normalized_aggregate
// Degree-normalized neighbor aggregation with bias and optional ReLU.
// ----------------------------------------------------------------------------
// One beat at a time. A bias load passes through the prepare and bias states
// before the next acceptance. A message element passes through prepare,
// multiply and accumulate, plus a final state on a last neighbor, when its
// degree product equals that of the last computed scale (the last scale is
// kept); otherwise it also waits in the scale state for the bit-serial
// divide, square root and done state of the scale unit. A last neighbor waits
// further while the output register holds a stalled result. Accumulators and
// biases live in two 64-entry synchronous memories; results leave through an
// output register, so a new beat is taken while a result waits.
`default_nettype none

module gcn_normalized_aggregate
	import gna_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 msg_valid,
	output logic                      msg_stall,
	input  wire msg_t                 msg,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output res_t                      res
);

	gna_state_t state_q, state_d;

	logic [VLEN_BITS-1:0] vlen_q;
	logic                 relu_q;

	msg_t                 m_q;
	logic [PROD_BITS-1:0] p_raw;
	logic [PROD_BITS-1:0] p_s;
	logic [PROD_BITS-1:0] cache_p_q;
	logic                 cache_vld_q;
	logic [31:0]          s_q;
	logic                 hit;

	logic signed [ACC_BITS-1:0]   acc_mem [MAX_DIM];
	logic signed [VALUE_BITS-1:0] bias_mem [MAX_DIM];
	logic signed [ACC_BITS-1:0]   acc_rd_q;
	logic signed [VALUE_BITS-1:0] bias_rd_q;

	logic [63:0]                  prod_q;
	logic signed [ACC_BITS-1:0]   acc_new_q;

	rsq_req_t rreq;
	rsq_rsp_t rrsp;

	logic                         accept;
	logic                         neg;
	logic [31:0]                  mag;
	logic [63:0]                  rnd_sum;
	logic signed [33:0]           term;
	logic signed [ACC_BITS:0]     acc_sum;
	logic signed [ACC_BITS-1:0]   acc_new;
	logic signed [ACC_BITS:0]     r_sum;
	logic signed [ACC_BITS:0]     r_relu;
	logic signed [VALUE_BITS-1:0] r_clamp;
	logic                         r_sat;
	logic                         out_free;
	logic                         load_out;

	localparam logic signed [ACC_BITS:0] ACC_HI = (ACC_BITS+1)'((64'sd1 <<< (ACC_BITS-1)) - 1);
	localparam logic signed [ACC_BITS:0] ACC_LO = -ACC_HI - 1;
	localparam logic signed [ACC_BITS:0] VAL_HI =
		(ACC_BITS+1)'((64'sd1 <<< (VALUE_BITS-1)) - 1);
	localparam logic signed [ACC_BITS:0] VAL_LO = -VAL_HI - 1;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_RELU) ? {31'd0, relu_q} : {25'd0, vlen_q};
	assign msg_stall = (state_q != ST_IDLE);
	assign accept    = msg_valid && !msg_stall;
	assign out_free  = !res_valid || !res_stall;

	assign p_raw = PROD_BITS'(m_q.node_degree) * PROD_BITS'(m_q.neighbor_degree);
	assign p_s   = (p_raw == '0) ? PROD_BITS'(1) : p_raw;
	assign hit   = cache_vld_q && (cache_p_q == p_s);

	assign rreq.start = (state_q == ST_PREP) && (m_q.command == CMD_MSG) && !hit;
	assign rreq.p     = p_s;

	gna_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	assign neg     = m_q.value[VALUE_BITS-1];
	assign mag     = neg ? (32'd0 - 32'(m_q.value)) : 32'(m_q.value);
	assign rnd_sum = prod_q + (64'd1 << 30);
	assign term    = neg ? -$signed({1'b0, rnd_sum[63:31]}) : $signed({1'b0, rnd_sum[63:31]});
	assign acc_sum = (ACC_BITS+1)'(acc_rd_q) + (ACC_BITS+1)'(term);

	always_comb begin
		if (m_q.first_neighbor) acc_new = ACC_BITS'(term);
		else if (acc_sum > ACC_HI) acc_new = ACC_HI[ACC_BITS-1:0];
		else if (acc_sum < ACC_LO) acc_new = ACC_LO[ACC_BITS-1:0];
		else acc_new = acc_sum[ACC_BITS-1:0];
	end

	assign r_sum  = (ACC_BITS+1)'(acc_new_q) + (ACC_BITS+1)'(bias_rd_q);
	assign r_relu = (relu_q && r_sum < 0) ? '0 : r_sum;

	always_comb begin
		r_sat   = 1'b0;
		r_clamp = r_relu[VALUE_BITS-1:0];
		if (r_relu > VAL_HI) begin
			r_sat   = 1'b1;
			r_clamp = VAL_HI[VALUE_BITS-1:0];
		end else if (r_relu < VAL_LO) begin
			r_sat   = 1'b1;
			r_clamp = VAL_LO[VALUE_BITS-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_PREP;
			ST_PREP: begin
				if (m_q.command == CMD_BIAS) state_d = ST_BIAS;
				else if (hit)                state_d = ST_MUL;
				else                         state_d = ST_SCALE;
			end
			ST_BIAS:  state_d = ST_IDLE;
			ST_SCALE: if (rrsp.done) state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = m_q.last_neighbor ? ST_FIN : ST_IDLE;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load_out = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vlen_q      <= VLEN_RESET;
			relu_q      <= 1'b1;
			cache_vld_q <= 1'b0;
			res_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_VLEN) vlen_q <= pwdata[VLEN_BITS-1:0];
				else                      relu_q <= pwdata[0];
			end
			if (rrsp.done) cache_vld_q <= 1'b1;
			if (load_out)       res_valid <= 1'b1;
			else if (!res_stall) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) m_q <= msg;
		if (rrsp.done) begin
			s_q       <= rrsp.s;
			cache_p_q <= p_s;
		end
		if (state_q == ST_MUL) prod_q <= 64'(mag) * 64'(s_q);
		if (state_q == ST_ACC) begin
			acc_new_q                <= acc_new;
			acc_mem[m_q.element_index] <= acc_new;
		end
		if (state_q == ST_BIAS) bias_mem[m_q.element_index] <= m_q.value;
		acc_rd_q  <= acc_mem[m_q.element_index];
		bias_rd_q <= bias_mem[m_q.element_index];
		if (load_out) begin
			res.out_index    <= m_q.element_index;
			res.result_value <= r_clamp;
			res.last_element <= ({1'b0, m_q.element_index} + 7'd1) == vlen_q;
			res.saturated    <= r_sat;
		end
	end

endmodule

`default_nettype wire
